[sv/tcpmq_pkg.sv]
// ============================================================================
// tcpmq_pkg
// Shared types and codes for the two-class priority multiqueue.
// ============================================================================
package tcpmq_pkg;

    localparam int IDX_W   = 5;
    localparam int ID_W    = 16;
    localparam int LIMIT_W = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TAKE = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] queue_index;
        logic             urgent_flag;
        logic [ID_W-1:0]  entry_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] taken_id;
        logic            taken_urgent;
    } t_out_item;

endpackage

[sv/tcpmq_ptr_table.sv]
// ============================================================================
// tcpmq_ptr_table
// Per-queue head and count memory for both classes, with registered read
// and one valid bit per queue so that an unwritten queue reads as empty.
// ============================================================================
module tcpmq_ptr_table #(
    parameter int QA_W  = 5,
    parameter int HD_W  = 3,
    parameter int CNT_W = 4,
    parameter int DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [QA_W-1:0]  i_rd_idx,
    output logic [HD_W-1:0]  o_u_head,
    output logic [CNT_W-1:0] o_u_cnt,
    output logic [HD_W-1:0]  o_r_head,
    output logic [CNT_W-1:0] o_r_cnt,
    input  logic             i_wr_en,
    input  logic [QA_W-1:0]  i_wr_idx,
    input  logic [HD_W-1:0]  i_u_head,
    input  logic [CNT_W-1:0] i_u_cnt,
    input  logic [HD_W-1:0]  i_r_head,
    input  logic [CNT_W-1:0] i_r_cnt
);

    localparam int REC_W = 2 * (HD_W + CNT_W);

    logic [REC_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [REC_W-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [REC_W-1:0] rd_rec;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= {i_u_head, i_u_cnt, i_r_head, i_r_cnt};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_idx];
            end
        end
    end

    // A queue that was never written holds zero heads and counts.
    assign rd_rec = r_rd_vld ? r_rd_data : '0;
    assign {o_u_head, o_u_cnt, o_r_head, o_r_cnt} = rd_rec;

endmodule

[sv/tcpmq_entry_store.sv]
// ============================================================================
// tcpmq_entry_store
// Identifier memories for the urgent and the regular class, one write and
// one registered read per cycle.
// ============================================================================
module tcpmq_entry_store #(
    parameter int SA_W  = 8,
    parameter int SLOTS = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic                     i_wr_urgent,
    input  logic [SA_W-1:0]          i_wr_addr,
    input  logic [tcpmq_pkg::ID_W-1:0] i_wr_data,
    input  logic                     i_rd_en,
    input  logic                     i_rd_urgent,
    input  logic [SA_W-1:0]          i_rd_addr,
    output logic [tcpmq_pkg::ID_W-1:0] o_rd_data
);

    logic [tcpmq_pkg::ID_W-1:0] r_mem_u [SLOTS];
    logic [tcpmq_pkg::ID_W-1:0] r_mem_r [SLOTS];
    logic [tcpmq_pkg::ID_W-1:0] r_rd_u;
    logic [tcpmq_pkg::ID_W-1:0] r_rd_r;
    logic                       r_rd_sel;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_urgent) begin
            r_mem_u[i_wr_addr] <= i_wr_data;
        end
        if (i_wr_en && !i_wr_urgent) begin
            r_mem_r[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_u <= r_mem_u[i_rd_addr];
            r_rd_r <= r_mem_r[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_sel <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_sel <= i_rd_urgent;
        end
    end

    assign o_rd_data = r_rd_sel ? r_rd_u : r_rd_r;

endmodule

[sv/two_class_priority_multiqueue.sv]
// ============================================================================
// two_class_priority_multiqueue
// A bank of bounded queues with strict two-class priority: takes return the
// oldest urgent entry first, then the oldest regular entry.
// ============================================================================
//
//  Channel  Direction  Handshake                     Payload
//  -------  ---------  ----------------------------  -------------------------
//  in       input      i_in_valid / o_in_ready       i_in  (tcpmq_pkg::t_in_item)
//  out      output     o_out_valid / i_out_ready     o_out (tcpmq_pkg::t_out_item)
//  cfg      input      i_cfg_valid / o_cfg_ready     i_cfg_data (capacity limit)
//
//  An add and an empty take load their result into the output register from
//  S_EXEC, which follows the input transfer and the registered pointer table
//  read. A take that finds an entry moves on to S_TAKE for the registered
//  entry memory read and loads its result from there.
//  A new item is accepted the cycle after the previous result is loaded,
//  even while that result still waits in the output register.
//  A stalled output holds the item in its final step until the output
//  register frees. Reset is synchronous and active low and clears the
//  per-queue valid bits at once, so every queue starts empty.
//
module two_class_priority_multiqueue #(
    parameter int QUEUE_COUNT = 32,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tcpmq_pkg::t_in_item           i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tcpmq_pkg::t_out_item          o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcpmq_pkg::LIMIT_W-1:0] i_cfg_data
);

    localparam int QA_W   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int HD_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS  = QUEUE_COUNT * QUEUE_DEPTH;
    localparam int SA_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_TAKE = 2'd2;

    logic [1:0]                    r_state, n_state;
    tcpmq_pkg::t_in_item           r_item;
    logic [tcpmq_pkg::LIMIT_W-1:0] r_limit;
    logic                          r_out_valid, n_out_valid;
    tcpmq_pkg::t_out_item          r_out, n_out;
    logic                          r_take_urgent, n_take_urgent;

    logic             in_xfer;
    logic             out_free;
    logic             in_range;
    logic             full;
    logic [CNT_W:0]   total;
    logic [CNT_W:0]   tail_sum;
    logic [HD_W-1:0]  tail;
    logic [HD_W-1:0]  head_sel;
    logic [HD_W:0]    head_inc;
    logic [HD_W-1:0]  head_next;

    logic [HD_W-1:0]  pt_u_head, pt_r_head;
    logic [CNT_W-1:0] pt_u_cnt, pt_r_cnt;
    logic             pt_wr_en;
    logic [HD_W-1:0]  w_u_head, w_r_head;
    logic [CNT_W-1:0] w_u_cnt, w_r_cnt;

    logic                       es_wr_en;
    logic                       es_rd_en;
    logic [SA_W-1:0]            es_wr_addr;
    logic [SA_W-1:0]            es_rd_addr;
    logic [tcpmq_pkg::ID_W-1:0] es_rd_data;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The user must change the limit only while the block is idle; the block does
    // not enforce this itself and is always ready to take a configuration transfer.
    assign o_cfg_ready = 1'b1;

    tcpmq_ptr_table #(
        .QA_W  (QA_W),
        .HD_W  (HD_W),
        .CNT_W (CNT_W),
        .DEPTH (QUEUE_COUNT)
    ) u_ptr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (in_xfer),
        .i_rd_idx (QA_W'(i_in.queue_index)),
        .o_u_head (pt_u_head),
        .o_u_cnt  (pt_u_cnt),
        .o_r_head (pt_r_head),
        .o_r_cnt  (pt_r_cnt),
        .i_wr_en  (pt_wr_en),
        .i_wr_idx (QA_W'(r_item.queue_index)),
        .i_u_head (w_u_head),
        .i_u_cnt  (w_u_cnt),
        .i_r_head (w_r_head),
        .i_r_cnt  (w_r_cnt)
    );

    tcpmq_entry_store #(
        .SA_W  (SA_W),
        .SLOTS (SLOTS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (es_wr_en),
        .i_wr_urgent (r_item.urgent_flag),
        .i_wr_addr   (es_wr_addr),
        .i_wr_data   (r_item.entry_id),
        .i_rd_en     (es_rd_en),
        .i_rd_urgent (n_take_urgent),
        .i_rd_addr   (es_rd_addr),
        .o_rd_data   (es_rd_data)
    );

    // Queue occupancy and the capacity check. A limit above the depth acts
    // as the depth, and a limit of zero refuses every add.
    assign in_range = int'(r_item.queue_index) < QUEUE_COUNT;
    assign total    = (CNT_W + 1)'(pt_u_cnt) + (CNT_W + 1)'(pt_r_cnt);
    assign full     = !in_range || (int'(total) >= int'(r_limit))
                      || (int'(total) >= QUEUE_DEPTH);

    // Tail slot of the class being added to, wrapped inside the queue.
    assign tail_sum = r_item.urgent_flag ? ((CNT_W + 1)'(pt_u_head) + (CNT_W + 1)'(pt_u_cnt))
                                         : ((CNT_W + 1)'(pt_r_head) + (CNT_W + 1)'(pt_r_cnt));
    assign tail     = (int'(tail_sum) >= QUEUE_DEPTH)
                      ? HD_W'(int'(tail_sum) - QUEUE_DEPTH) : HD_W'(tail_sum);

    // Head of the class that a take serves, and its advanced value.
    assign head_sel  = (pt_u_cnt != '0) ? pt_u_head : pt_r_head;
    assign head_inc  = (HD_W + 1)'(head_sel) + (HD_W + 1)'(1);
    assign head_next = (int'(head_inc) >= QUEUE_DEPTH) ? '0 : HD_W'(head_inc);

    assign es_wr_addr = SA_W'(int'(r_item.queue_index) * QUEUE_DEPTH + int'(tail));
    assign es_rd_addr = SA_W'(int'(r_item.queue_index) * QUEUE_DEPTH + int'(head_sel));

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out         = r_out;
        n_take_urgent = r_take_urgent;
        pt_wr_en      = 1'b0;
        w_u_head      = pt_u_head;
        w_u_cnt       = pt_u_cnt;
        w_r_head      = pt_r_head;
        w_r_cnt       = pt_r_cnt;
        es_wr_en      = 1'b0;
        es_rd_en      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_item.kind == tcpmq_pkg::KIND_ADD) begin
                    // Pointer update and entry write commit together with
                    // the result, so a stalled output changes nothing.
                    if (out_free) begin
                        n_out_valid        = 1'b1;
                        n_out.status       = full ? tcpmq_pkg::STATUS_FULL
                                                  : tcpmq_pkg::STATUS_DONE;
                        n_out.taken_id     = '0;
                        n_out.taken_urgent = 1'b0;
                        if (!full) begin
                            pt_wr_en = 1'b1;
                            es_wr_en = 1'b1;
                            if (r_item.urgent_flag) begin
                                w_u_cnt = pt_u_cnt + CNT_W'(1);
                            end else begin
                                w_r_cnt = pt_r_cnt + CNT_W'(1);
                            end
                        end
                        n_state = S_IDLE;
                    end
                end else if (!in_range || (pt_u_cnt == '0 && pt_r_cnt == '0)) begin
                    if (out_free) begin
                        n_out_valid        = 1'b1;
                        n_out.status       = tcpmq_pkg::STATUS_EMPTY;
                        n_out.taken_id     = '0;
                        n_out.taken_urgent = 1'b0;
                        n_state            = S_IDLE;
                    end
                end else begin
                    // Start the entry read and retire the head right away;
                    // the read data register holds the identifier until the
                    // output register can take it.
                    es_rd_en      = 1'b1;
                    pt_wr_en      = 1'b1;
                    n_take_urgent = (pt_u_cnt != '0);
                    if (pt_u_cnt != '0) begin
                        w_u_head = head_next;
                        w_u_cnt  = pt_u_cnt - CNT_W'(1);
                    end else begin
                        w_r_head = head_next;
                        w_r_cnt  = pt_r_cnt - CNT_W'(1);
                    end
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = tcpmq_pkg::STATUS_DONE;
                    n_out.taken_id     = es_rd_data;
                    n_out.taken_urgent = r_take_urgent;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_take_urgent <= 1'b0;
            r_limit       <= tcpmq_pkg::LIMIT_RESET;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_take_urgent <= n_take_urgent;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_xfer) begin
            r_item <= i_in;
        end
    end

endmodule

[sv/tcpmq_checker.sv]
// ============================================================================
// tcpmq_checker
// Port-level checks for the two-class priority multiqueue, bound to the top.
// ============================================================================
module tcpmq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input tcpmq_pkg::t_in_item           i_in,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input tcpmq_pkg::t_out_item          o_out,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [tcpmq_pkg::LIMIT_W-1:0] i_cfg_data
);

    // A stalled result keeps its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // One item at a time: the block is busy right after an input transfer.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while an item is in progress");

    // A new result only appears after the block has been working on an item.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without an item in progress");

    // Refused adds and empty takes carry no identifier or class.
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != tcpmq_pkg::STATUS_DONE)
        |-> (o_out.taken_id == '0) && !o_out.taken_urgent)
        else $error("non-done result carries an identifier");

endmodule

bind two_class_priority_multiqueue tcpmq_checker u_tcpmq_checker (.*);

[dv/two_class_priority_multiqueue_tb.sv]
// ============================================================================
// two_class_priority_multiqueue_tb
// Self-checking testbench for the two-class priority multiqueue. A driver
// feeds operations from a backlog, a monitor predicts each reply from its own
// model of the queue bank, and every reply is checked field by field.
// ============================================================================
module two_class_priority_multiqueue_tb;

    import tcpmq_pkg::*;

    localparam int QCOUNT      = 32;
    localparam int QDEPTH      = 8;
    localparam int CLK_HALF    = 10;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int END_SETTLE  = 10;

    // Block ports. Every input holds a known value from time zero.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [LIMIT_W-1:0]   i_cfg_data  = '0;

    // Operations waiting for the driver and replies the queue model predicts.
    t_in_item  op_backlog[$];
    t_out_item predicted_replies[$];

    // Idle rates in percent, changed by the sequencer between phases.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Set by the monitor when the input transfer completed at the last edge.
    logic in_took = 1'b0;

    int cycles = 0;
    int fault_count = 0;
    int replies_checked = 0;
    int ops_sent = 0;

    // Tallies of what the model saw, reported at the end.
    int n_stored = 0;
    int n_full = 0;
    int n_take_urgent = 0;
    int n_take_regular = 0;
    int n_empty = 0;

    // Model of the queue bank: one circular FIFO per class per queue.
    logic [LIMIT_W-1:0] cap_limit;
    logic [ID_W-1:0]    urgent_slots  [QCOUNT][QDEPTH];
    logic [ID_W-1:0]    regular_slots [QCOUNT][QDEPTH];
    int                 urgent_head   [QCOUNT];
    int                 urgent_cnt    [QCOUNT];
    int                 regular_head  [QCOUNT];
    int                 regular_cnt   [QCOUNT];

    two_class_priority_multiqueue #(
        .QUEUE_COUNT(QCOUNT),
        .QUEUE_DEPTH(QDEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Applies one operation to the queue model and returns the reply the block
    // must give for it. A limit above the depth behaves as the depth, and a
    // limit of zero refuses every add.
    function automatic t_out_item apply_queue_op(t_in_item op);
        t_out_item reply;
        int        q;
        int        lim;
        reply = '0;
        q = int'(op.queue_index);
        if (op.kind == KIND_ADD) begin
            lim = (int'(cap_limit) > QDEPTH) ? QDEPTH : int'(cap_limit);
            if (q >= QCOUNT || urgent_cnt[q] + regular_cnt[q] >= lim) begin
                reply.status = STATUS_FULL;
                n_full++;
            end else begin
                if (op.urgent_flag) begin
                    urgent_slots[q][(urgent_head[q] + urgent_cnt[q]) % QDEPTH] = op.entry_id;
                    urgent_cnt[q]++;
                end else begin
                    regular_slots[q][(regular_head[q] + regular_cnt[q]) % QDEPTH] =
                        op.entry_id;
                    regular_cnt[q]++;
                end
                reply.status = STATUS_DONE;
                n_stored++;
            end
        end else begin
            if (q >= QCOUNT) begin
                reply.status = STATUS_EMPTY;
                n_empty++;
            end else if (urgent_cnt[q] != 0) begin
                // Urgent entries always leave first.
                reply.taken_id     = urgent_slots[q][urgent_head[q]];
                reply.taken_urgent = 1'b1;
                reply.status       = STATUS_DONE;
                urgent_head[q]     = (urgent_head[q] + 1) % QDEPTH;
                urgent_cnt[q]--;
                n_take_urgent++;
            end else if (regular_cnt[q] != 0) begin
                reply.taken_id = regular_slots[q][regular_head[q]];
                reply.status   = STATUS_DONE;
                regular_head[q] = (regular_head[q] + 1) % QDEPTH;
                regular_cnt[q]--;
                n_take_regular++;
            end else begin
                reply.status = STATUS_EMPTY;
                n_empty++;
            end
        end
        return reply;
    endfunction

    function automatic t_in_item make_op(logic kind, int q, logic urgent, int id);
        t_in_item op;
        op.kind        = kind;
        op.queue_index = IDX_W'(q);
        op.urgent_flag = urgent;
        op.entry_id    = ID_W'(id);
        return op;
    endfunction

    // Driver: changes the input channel at the falling edge only. A new
    // operation is offered once the previous one has been transferred, and
    // the receiver side stalls at random on the same edge.
    always @(negedge i_clk) begin
        t_in_item next_op;
        logic     next_valid;
        next_op    = i_in;
        next_valid = i_in_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!i_in_valid || in_took) begin
            next_valid = 1'b0;
            if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_op    = op_backlog.pop_front();
                next_valid = 1'b1;
            end
        end
        i_in_valid  <= next_valid;
        i_in        <= next_op;
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: samples both channels at the rising edge. The reply is checked
    // before the new prediction is queued, so an early reply cannot match the
    // operation transferred at the same edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (predicted_replies.size() == 0) begin
                    $display("%0t: reply with none pending: status %0d id %h urgent %0b",
                             $time, o_out.status, o_out.taken_id, o_out.taken_urgent);
                    fault_count++;
                end else begin
                    want = predicted_replies.pop_front();
                    if (o_out.status !== want.status || o_out.taken_id !== want.taken_id ||
                        o_out.taken_urgent !== want.taken_urgent) begin
                        $display("%0t: reply mismatch: expected status %0d id %h urgent %0b,",
                                 $time, want.status, want.taken_id, want.taken_urgent);
                        $display("%0t:   actual status %0d id %h urgent %0b",
                                 $time, o_out.status, o_out.taken_id, o_out.taken_urgent);
                        fault_count++;
                    end
                    replies_checked++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                predicted_replies.push_back(apply_queue_op(i_in));
                ops_sent++;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Blocks until every queued operation has been transferred and every
    // predicted reply has come back, so the block is idle.
    task automatic wait_idle();
        while (op_backlog.size() != 0 || i_in_valid || predicted_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // Writes the capacity limit through its own channel and mirrors it into
    // the model at the edge of the transfer.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cap_limit = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random operations. Most of them hit a window of three neighboring queues
    // so that queues fill up, wrap and drain; the add rate swings between
    // bursts of filling and bursts of draining.
    task automatic queue_random_ops(input int count);
        t_in_item op;
        int       n;
        int       base;
        int       add_pct;
        base = $urandom_range(QCOUNT - 1);
        for (n = 0; n < count; n++) begin
            add_pct  = ((n / 24) % 2) ? 35 : 70;
            op.kind  = ($urandom_range(99) < add_pct) ? KIND_ADD : KIND_TAKE;
            if ($urandom_range(99) < 75)
                op.queue_index = IDX_W'((base + $urandom_range(2)) % QCOUNT);
            else
                op.queue_index = IDX_W'($urandom_range(QCOUNT - 1));
            op.urgent_flag = 1'($urandom_range(1));
            case ($urandom_range(9))
                0:       op.entry_id = '0;
                1:       op.entry_id = '1;
                default: op.entry_id = ID_W'($urandom_range(16'hFFFF));
            endcase
            op_backlog.push_back(op);
        end
    endtask

    initial begin
        int q;
        cap_limit = LIMIT_RESET;
        for (q = 0; q < QCOUNT; q++) begin
            urgent_head[q]  = 0;
            urgent_cnt[q]   = 0;
            regular_head[q] = 0;
            regular_cnt[q]  = 0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 20;
        recv_stall_pct = 51;

        // Reset limit of five: fill queue 0 with both classes, get one add
        // refused, then drain it in priority order and hit the empty case.
        op_backlog.push_back(make_op(KIND_ADD, 0, 1'b0, 16'h0000));
        op_backlog.push_back(make_op(KIND_ADD, 0, 1'b1, 16'hFFFF));
        op_backlog.push_back(make_op(KIND_ADD, 0, 1'b0, 16'h1234));
        op_backlog.push_back(make_op(KIND_ADD, 0, 1'b1, 16'h00FF));
        op_backlog.push_back(make_op(KIND_ADD, 0, 1'b0, 16'hFF00));
        op_backlog.push_back(make_op(KIND_ADD, 0, 1'b1, 16'hAAAA));
        op_backlog.push_back(make_op(KIND_TAKE, 0, 1'b0, 16'h0000));
        op_backlog.push_back(make_op(KIND_TAKE, 0, 1'b1, 16'h5555));
        op_backlog.push_back(make_op(KIND_TAKE, 0, 1'b0, 16'hFFFF));
        op_backlog.push_back(make_op(KIND_TAKE, 0, 1'b1, 16'h0000));
        op_backlog.push_back(make_op(KIND_TAKE, 0, 1'b0, 16'h0000));
        op_backlog.push_back(make_op(KIND_TAKE, 0, 1'b0, 16'h0000));
        op_backlog.push_back(make_op(KIND_ADD, 31, 1'b1, 16'h5555));
        op_backlog.push_back(make_op(KIND_TAKE, 31, 1'b0, 16'hFFFF));
        wait_idle();

        // A limit of zero refuses every add; the queue then reads empty.
        write_limit(4'd0);
        op_backlog.push_back(make_op(KIND_ADD, 3, 1'b1, 16'hBEEF));
        op_backlog.push_back(make_op(KIND_TAKE, 3, 1'b0, 16'h0000));
        wait_idle();

        // A limit above the depth acts as the depth: eight adds fit, the
        // ninth is refused.
        write_limit(4'd15);
        for (q = 0; q < 9; q++)
            op_backlog.push_back(make_op(KIND_ADD, 7, q[0], 16'hC000 + q));
        op_backlog.push_back(make_op(KIND_TAKE, 7, 1'b0, 16'h0000));
        op_backlog.push_back(make_op(KIND_TAKE, 7, 1'b0, 16'h0000));
        wait_idle();

        write_limit(4'd8);
        queue_random_ops(400);
        wait_idle();

        send_idle_pct  = 51;
        recv_stall_pct = 20;
        write_limit(4'd1);
        queue_random_ops(150);
        wait_idle();

        write_limit(4'd3);
        queue_random_ops(250);
        wait_idle();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_limit(4'd15);
        queue_random_ops(200);
        wait_idle();

        write_limit(LIMIT_W'($urandom_range(15)));
        queue_random_ops(150);
        wait_idle();

        // Let any stray reply show up before the verdict.
        repeat (END_SETTLE) @(posedge i_clk);

        $display("Checked %0d replies for %0d operations over eight capacity settings.",
                 replies_checked, ops_sent);
        $display("Stored %0d, refused full %0d, took %0d urgent and %0d regular, %0d empty.",
                 n_stored, n_full, n_take_urgent, n_take_regular, n_empty);
        if (fault_count == 0 && predicted_replies.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d faults, %0d replies never arrived", fault_count,
                     predicted_replies.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
